/* hdl/ird_pkg.sv */
// ----------------------------------------------------------------------------
// ird_pkg: shared definitions for the radix digit converter
// Widths, character codes, the cell control bundle and the digit-to-ASCII
// mapping used by the sequencer and the digit cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ird_pkg;

  // Default width of the converted number.
  localparam int VALUE_BITS_DEF = 64;

  // Fixed field widths.
  localparam int INPUT_W = 64;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  // Base limits and the only base that takes a sign.
  localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] MAX_RADIX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DEC_RADIX = RADIX_W'(10);

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_UPPER = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2D);
  localparam logic [CHAR_W-1:0] CHAR_NONE  = CHAR_W'(0);

  // Control bundle from the sequencer to every digit cell.
  typedef struct packed {
    logic clear;  // zero the digit before a conversion
    logic shift;  // move each digit one cell toward the top
  } cell_ctl_t;

  // Map a digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DEC_RADIX) begin
      digit_char = CHAR_ZERO + dx;
    end else begin
      digit_char = CHAR_UPPER + dx - CHAR_W'(DEC_RADIX);
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/ird_digit_cell.sv */
// ----------------------------------------------------------------------------
// ird_digit_cell: one digit position of the conversion row
// Doubles its digit and adds the incoming carry each time the conversion
// token passes, reducing modulo the base and passing the carry upward in a
// register. During output it acts as one stage of a shift register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ird_digit_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ird_pkg::cell_ctl_t          ctl,
  input  wire logic [ird_pkg::RADIX_W-1:0] radix,
  input  wire logic                        act_in,
  input  wire logic                        carry_in,
  input  wire logic [ird_pkg::RADIX_W-1:0] shift_in,
  output logic      [ird_pkg::RADIX_W-1:0] digit,
  output logic                             carry_out,
  output logic                             act_out
);

  logic [ird_pkg::RADIX_W-1:0] digit_r;
  logic [ird_pkg::RADIX_W-1:0] digit_nxt;
  logic                        carry_r;
  logic                        act_r;
  logic [ird_pkg::RADIX_W:0]   dbl;
  logic [ird_pkg::RADIX_W:0]   diff;
  logic                        ge;

  // Twice the digit plus the carry, then a single conditional subtract.
  assign dbl       = {digit_r, carry_in};
  assign diff      = dbl - {1'b0, radix};
  assign ge        = (dbl >= {1'b0, radix});
  assign digit_nxt = ge ? diff[ird_pkg::RADIX_W-1:0] : dbl[ird_pkg::RADIX_W-1:0];

  // Digit register: clear, convert step or output shift.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit_r <= '0;
    end else if (act_in) begin
      digit_r <= digit_nxt;
    end else if (ctl.shift) begin
      digit_r <= shift_in;
    end
  end

  // The carry travels with the token to the next cell.
  always_ff @(posedge clk) begin
    carry_r <= ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_in;
    end
  end

  assign digit     = digit_r;
  assign carry_out = carry_r;
  assign act_out   = act_r;

endmodule

`default_nettype wire

/* hdl/ird_sequencer.sv */
// ----------------------------------------------------------------------------
// ird_sequencer: input checks, bit feed and character output control
// Validates the request, forms the magnitude, feeds it most significant bit
// first into the digit row, then drops leading zeros and hands out the
// characters one transaction at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ird_sequencer #(
  parameter int VALUE_BITS = ird_pkg::VALUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ird_pkg::INPUT_W-1:0] in_value,
  input  wire logic [ird_pkg::RADIX_W-1:0] in_radix,
  input  wire logic                        in_req_type,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [ird_pkg::CHAR_W-1:0]  out_char_code,
  output logic                             out_is_last,
  output logic                             out_is_empty,
  input  wire logic [ird_pkg::RADIX_W-1:0] top_digit,
  output ird_pkg::cell_ctl_t               ctl,
  output logic      [ird_pkg::RADIX_W-1:0] radix,
  output logic                             feed_act,
  output logic                             feed_bit
);

  localparam int CNT_W = $clog2(2 * VALUE_BITS);
  localparam int REM_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_SIGN  = 6'b000100,
    ST_SKIP  = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_EMPTY = 6'b100000
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [VALUE_BITS-1:0]       mag_r;
  logic [VALUE_BITS-1:0]       mag_nxt;
  logic [ird_pkg::RADIX_W-1:0] radix_r;
  logic                        neg_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [CNT_W-1:0]            cnt_nxt;
  logic [REM_W-1:0]            rem_r;
  logic [REM_W-1:0]            rem_nxt;
  logic [VALUE_BITS-1:0]       val;
  logic                        neg;
  logic                        bad;
  logic                        accept;
  logic                        out_hs;
  logic                        rem_one;
  logic                        skip_zero;

  // Request decode on the input side.
  assign val    = in_value[VALUE_BITS-1:0];
  assign neg    = in_req_type & val[VALUE_BITS-1];
  assign bad    = !(in_radix inside {[ird_pkg::MIN_RADIX:ird_pkg::MAX_RADIX]}) ||
                  (neg && (in_radix != ird_pkg::DEC_RADIX));
  assign accept = in_valid && in_ready;
  assign out_hs = out_valid && out_ready;

  assign rem_one   = (rem_r == REM_W'(1));
  assign skip_zero = (top_digit == '0) && !rem_one;

  // Next state and counters.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    mag_nxt   = mag_r;
    ctl.clear = 1'b0;
    ctl.shift = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.clear = 1'b1;
          cnt_nxt   = '0;
          mag_nxt   = neg ? (~val + VALUE_BITS'(1)) : val;
          state_nxt = bad ? ST_EMPTY : ST_CONV;
        end
      end
      ST_CONV: begin
        mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(2 * VALUE_BITS - 2)) begin
          rem_nxt   = REM_W'(VALUE_BITS);
          state_nxt = neg_r ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (out_hs) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (skip_zero) begin
          ctl.shift = 1'b1;
          rem_nxt   = rem_r - REM_W'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_hs) begin
          if (rem_one) begin
            state_nxt = ST_IDLE;
          end else begin
            ctl.shift = 1'b1;
            rem_nxt   = rem_r - REM_W'(1);
          end
        end
      end
      ST_EMPTY: begin
        if (out_hs) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Request payload registers.
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    if (accept) begin
      radix_r <= in_radix;
      neg_r   <= neg;
    end
  end

  // Bit feed into the lowest digit cell.
  assign feed_act = (state_r == ST_CONV) && (cnt_r < CNT_W'(VALUE_BITS));
  assign feed_bit = mag_r[VALUE_BITS-1];
  assign radix    = radix_r;

  // Output channel, driven from registered state and the top digit.
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SIGN) || (state_r == ST_EMIT) ||
                     (state_r == ST_EMPTY);

  always_comb begin
    case (state_r)
      ST_SIGN: begin
        out_char_code = ird_pkg::CHAR_MINUS;
        out_is_last   = 1'b0;
        out_is_empty  = 1'b0;
      end
      ST_EMIT: begin
        out_char_code = ird_pkg::digit_char(top_digit);
        out_is_last   = rem_one;
        out_is_empty  = 1'b0;
      end
      ST_EMPTY: begin
        out_char_code = ird_pkg::CHAR_NONE;
        out_is_last   = 1'b1;
        out_is_empty  = 1'b1;
      end
      default: begin
        out_char_code = ird_pkg::CHAR_NONE;
        out_is_last   = 1'b0;
        out_is_empty  = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/integer_to_radix_digits.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_digits: number to ASCII digit string in bases 2 to 36
// Top level: the request sequencer and a row of digit cells.
// ----------------------------------------------------------------------------
// One request is converted at a time. A valid request is first loaded,
// then its bits are fed in and their carries ripple through the row of
// VALUE_BITS digit cells, each cell passing its carry to the next through a
// register. A leading minus sign is handed out next, then each leading zero
// digit is dropped, the skip phase is left, and the remaining digits are
// handed out one per character transaction, most significant first.
// Dropped zeros and handed-out digits always add up to VALUE_BITS. An
// invalid base, or a negative signed value outside base 10, gives one
// empty result on the cycle after the request is taken. A new request is
// taken once the last character has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_digits #(
  parameter int VALUE_BITS = ird_pkg::VALUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ird_pkg::INPUT_W-1:0] in_value,
  input  wire logic [ird_pkg::RADIX_W-1:0] in_radix,
  input  wire logic                        in_req_type,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [ird_pkg::CHAR_W-1:0]  out_char_code,
  output logic                             out_is_last,
  output logic                             out_is_empty
);

  ird_pkg::cell_ctl_t          ctl;
  logic [ird_pkg::RADIX_W-1:0] radix;
  logic                        feed_act;
  logic                        feed_bit;
  logic [ird_pkg::RADIX_W-1:0] digit [VALUE_BITS];
  logic                        carry [VALUE_BITS];
  logic                        act   [VALUE_BITS];

  // Request control and character output.
  ird_sequencer #(
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .in_req_type   (in_req_type),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last),
    .out_is_empty  (out_is_empty),
    .top_digit     (digit[VALUE_BITS-1]),
    .ctl           (ctl),
    .radix         (radix),
    .feed_act      (feed_act),
    .feed_bit      (feed_bit)
  );

  // Digit row: cell 0 holds the least significant digit.
  for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      ird_digit_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .radix     (radix),
        .act_in    (feed_act),
        .carry_in  (feed_bit),
        .shift_in  ('0),
        .digit     (digit[i]),
        .carry_out (carry[i]),
        .act_out   (act[i])
      );
    end else begin : g_rest
      ird_digit_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .radix     (radix),
        .act_in    (act[i-1]),
        .carry_in  (carry[i-1]),
        .shift_in  (digit[i-1]),
        .digit     (digit[i]),
        .carry_out (carry[i]),
        .act_out   (act[i])
      );
    end
  end

endmodule

`default_nettype wire

/* hdl/ird_checker.sv */
// ----------------------------------------------------------------------------
// ird_checker: port-level checks for the radix digit converter
// Watches the top level's channels and flags ordering and framing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ird_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ird_pkg::CHAR_W-1:0]  out_char_code,
  input wire logic                        out_is_last,
  input wire logic                        out_is_empty
);

  // An empty result is always a single, final transaction.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_is_last &&
                                  (out_char_code == ird_pkg::CHAR_NONE))
    else $error("empty result not marked last or carries a character");

  // No new request is taken while a result is still on offer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // A taken request keeps the input side busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a request was taken");

  // The block is ready again right after the final transaction.
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_last |=> in_ready && !out_valid)
    else $error("not ready after the final character");

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) &&
                                $stable(out_is_last))
    else $error("stalled result changed");

endmodule

bind integer_to_radix_digits ird_checker u_ird_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char_code (out_char_code),
  .out_is_last   (out_is_last),
  .out_is_empty  (out_is_empty)
);

`default_nettype wire
